// ----- rtl/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg: shared types, constants and helpers for quaternion_to_euler
// Widths, CORDIC arctangent table, quarter turn and output rounding.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NCELL = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int VW    = 38;   // CORDIC x/y width
  localparam int ZW    = 24;   // angle accumulator, Q20 radians
  localparam int SQW   = 58;   // square root datapath width
  localparam int NSQ   = 29;   // square root digits
  localparam int SW    = 5;    // cell index width

  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [17:0]   HALF_PI_Q13 = 18'sd12868;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } q2e_vec_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] r;
  } q2e_sq_t;

  typedef struct packed {
    logic signed [VW-1:0] rs;
    logic signed [VW-1:0] rc;
    logic signed [VW-1:0] ys;
    logic signed [VW-1:0] yc;
    logic signed [29:0]   sp;
    logic                 clmp;
    logic                 cneg;
  } q2e_lane_t;

  typedef struct packed {
    logic clmp;
    logic cneg;
  } q2e_flag_t;

  // atan(2^-i), Q20 radians
  function automatic logic signed [ZW-1:0] atan_q20(input logic [SW-1:0] i);
    logic signed [ZW-1:0] a;
    a = '0;
    case (i)
      5'd0:    a = 24'sd823550;
      5'd1:    a = 24'sd486170;
      5'd2:    a = 24'sd256879;
      5'd3:    a = 24'sd130396;
      5'd4:    a = 24'sd65451;
      5'd5:    a = 24'sd32757;
      5'd6:    a = 24'sd16383;
      5'd7:    a = 24'sd8192;
      5'd8:    a = 24'sd4096;
      5'd9:    a = 24'sd2048;
      5'd10:   a = 24'sd1024;
      5'd11:   a = 24'sd512;
      5'd12:   a = 24'sd256;
      5'd13:   a = 24'sd128;
      5'd14:   a = 24'sd64;
      5'd15:   a = 24'sd32;
      5'd16:   a = 24'sd16;
      5'd17:   a = 24'sd8;
      5'd18:   a = 24'sd4;
      5'd19:   a = 24'sd2;
      5'd20:   a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // bring a left-half-plane vector into the right half plane
  function automatic q2e_vec_t qturn(input logic signed [VW-1:0] y,
                                     input logic signed [VW-1:0] x);
    q2e_vec_t o;
    o.x = x;
    o.y = y;
    o.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        o.x = y;
        o.y = -x;
        o.z = HALF_PI_Q20;
      end else begin
        o.x = -y;
        o.y = x;
        o.z = -HALF_PI_Q20;
      end
    end
    return o;
  endfunction

  // Q20 -> Q13, round half up, saturate to +-lim
  function automatic logic signed [17:0] rnd_sat(input logic signed [ZW-1:0] z,
                                                 input logic signed [17:0] lim);
    logic signed [ZW:0] t;
    logic signed [17:0] r;
    t = (25'(z) + 25'sd64) >>> 7;
    r = t[17:0];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

// ----- rtl/quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler: Q1.14 quaternion to ZYX Euler, Q2.13 rad (pitch Q1.13)
// Products, pitch cosine by square root, three CORDIC arctangent chains.
//
//   port group      dir  handshake         word
//   start/quat_*    in   start & !busy     quat_w, quat_x, quat_y, quat_z
//   done/results    out  done, one cycle   roll_angle, pitch_angle,
//                                           yaw_angle, pitch_clamped
//
// One word accepted per cycle; busy is always low.
// Stages: three product/sum stages, 29 square root cells, one quarter-turn
// stage, the CORDIC cells (CORDIC_STEPS, at most 24) and rounding.
// Reset clears the valid pipeline only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module quaternion_to_euler (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);
  import q2e_pkg::*;

  localparam int NV = 3 + NSQ + 1 + NCELL + 1;

  logic [NV-1:0] vld;

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  logic signed [VW-1:0] s_full;
  logic signed [VW-1:0] s_abs;
  logic                 s_clmp;
  q2e_lane_t            ln2;
  logic [27:0]          a2;
  logic [55:0]          asq;

  q2e_lane_t ln [0:NSQ];
  q2e_sq_t   sq [0:NSQ];

  q2e_vec_t  cr [0:NCELL];
  q2e_vec_t  cp [0:NCELL];
  q2e_vec_t  cy [0:NCELL];
  q2e_flag_t fl [0:NCELL];

  logic signed [17:0] pitch_r;

  assign busy = 1'b0;
  assign done = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NV-2:0], start};
    end
  end

  // products
  always_ff @(posedge clk) begin
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
  end

  // sums, Q28
  always_comb begin
    s_full = (VW'(p_wy) - VW'(p_zx)) <<< 1;
    s_abs  = (s_full < 0) ? -s_full : s_full;
    s_clmp = (s_full >= (VW'(1) <<< 28)) || (s_full <= -(VW'(1) <<< 28));
  end

  always_ff @(posedge clk) begin
    ln2.rs   <= (VW'(p_wx) + VW'(p_yz)) <<< 1;
    ln2.rc   <= (VW'(1) <<< 28) - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
    ln2.ys   <= (VW'(p_wz) + VW'(p_xy)) <<< 1;
    ln2.yc   <= (VW'(1) <<< 28) - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
    ln2.sp   <= s_full[29:0];
    ln2.clmp <= s_clmp;
    ln2.cneg <= s_full < 0;
    a2       <= s_clmp ? 28'd0 : s_abs[27:0];
  end

  // 1 - s^2, Q56
  assign asq = a2 * a2;

  always_ff @(posedge clk) begin
    ln[0]   <= ln2;
    sq[0].v <= (SQW'(1) << 56) - SQW'(asq);
    sq[0].r <= '0;
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk  (clk),
      .step (SW'(k)),
      .din  (sq[k]),
      .dout (sq[k+1])
    );

    always_ff @(posedge clk) begin
      ln[k+1] <= ln[k];
    end
  end

  // quarter turn into the right half plane
  always_ff @(posedge clk) begin
    cr[0]      <= qturn(ln[NSQ].rs, ln[NSQ].rc);
    cp[0]      <= qturn(VW'(ln[NSQ].sp), VW'(sq[NSQ].r[28:0]));
    cy[0]      <= qturn(ln[NSQ].ys, ln[NSQ].yc);
    fl[0].clmp <= ln[NSQ].clmp;
    fl[0].cneg <= ln[NSQ].cneg;
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_cordic
    q2e_cordic_cell u_roll (
      .clk  (clk),
      .step (SW'(j)),
      .din  (cr[j]),
      .dout (cr[j+1])
    );

    q2e_cordic_cell u_pitch (
      .clk  (clk),
      .step (SW'(j)),
      .din  (cp[j]),
      .dout (cp[j+1])
    );

    q2e_cordic_cell u_yaw (
      .clk  (clk),
      .step (SW'(j)),
      .din  (cy[j]),
      .dout (cy[j+1])
    );

    always_ff @(posedge clk) begin
      fl[j+1] <= fl[j];
    end
  end

  always_comb begin
    if (fl[NCELL].clmp) begin
      pitch_r = fl[NCELL].cneg ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      pitch_r = rnd_sat(cp[NCELL].z, HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    roll_angle    <= 16'(rnd_sat(cr[NCELL].z, PI_Q13));
    pitch_angle   <= 15'(pitch_r);
    yaw_angle     <= 16'(rnd_sat(cy[NCELL].z, PI_Q13));
    pitch_clamped <= fl[NCELL].clmp;
  end

endmodule

// ----- rtl/q2e_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one digit of a pipelined integer square root
// Resolves one result bit per cell and registers the remainder and root.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic                 clk,
  input  logic [q2e_pkg::SW-1:0] step,
  input  q2e_pkg::q2e_sq_t     din,
  output q2e_pkg::q2e_sq_t     dout
);
  import q2e_pkg::*;

  logic [SQW-1:0] bitv;
  logic [SQW-1:0] trial;
  q2e_sq_t        nxt;

  always_comb begin
    bitv  = SQW'(1) << (SQW'(56) - (SQW'(step) << 1));
    trial = din.r + bitv;
    if (din.v >= trial) begin
      nxt.v = din.v - trial;
      nxt.r = (din.r >> 1) + bitv;
    end else begin
      nxt.v = din.v;
      nxt.r = din.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ----- rtl/q2e_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring CORDIC micro-rotation
// Drives y toward zero; holds the vector once y is exactly zero.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
  input  logic                   clk,
  input  logic [q2e_pkg::SW-1:0] step,
  input  q2e_pkg::q2e_vec_t      din,
  output q2e_pkg::q2e_vec_t      dout
);
  import q2e_pkg::*;

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  q2e_vec_t             nxt;

  always_comb begin
    xs  = din.x >>> step;
    ys  = din.y >>> step;
    nxt = din;
    if (din.y < 0) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - atan_q20(step);
    end else if (din.y > 0) begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + atan_q20(step);
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ----- tb/tb_quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler: self-checking bench for quaternion_to_euler
// Directed corner table plus random quaternions at three idle mixes; every
// done word is compared with typed row angles or an in-bench CORDIC model.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler;
  import q2e_pkg::*;

  localparam int N_RAND     = 1250;
  localparam int LAT        = 34 + CORDIC_STEPS;
  localparam int MAX_CYCLES = 400000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clmp;
  } angles_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;
    angles_t            exp;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic busy, done, pitch_clamped;
  logic signed [15:0] roll_angle, yaw_angle;
  logic signed [14:0] pitch_angle;

  angles_t angles_q[$];
  int errors = 0, n_sent = 0, n_got = 0, n_clamp = 0;
  longint cycles = 0;
  int send_idle = 23;

  quaternion_to_euler DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_ref(int i);
    longint t[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1,
                      0, 0, 0};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint a, nx, ny;
    int steps;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; a = 1647099;
      end else begin
        nx = -y; ny = x; a = -1647099;
      end
      x = nx; y = ny;
    end
    for (int i = 0; i < steps; i++) begin
      if (y == 0) break;
      if (y < 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); a -= atan_ref(i);
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); a += atan_ref(i);
      end
      x = nx; y = ny;
    end
    return a;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, s, one, c;
    longint unsigned a;
    angles_t o;
    w = qw; x = qx; y = qy; z = qz;
    one = 64'sd1 << 28;
    o.roll = 16'(round_q13(vector_angle(2 * (w * x + y * z),
                                        one - 2 * (x * x + y * y)), 25736));
    o.yaw = 16'(round_q13(vector_angle(2 * (w * z + x * y),
                                       one - 2 * (y * y + z * z)), 25736));
    s = 2 * (w * y - z * x);
    o.clmp = 1'b0;
    if (s >= one) begin
      o.pitch = 15'sd12868; o.clmp = 1'b1;
    end else if (s <= -one) begin
      o.pitch = -15'sd12868; o.clmp = 1'b1;
    end else begin
      a = (s < 0) ? -s : s;
      c = longint'(root64((64'd1 << 56) - a * a));
      o.pitch = 15'(round_q13(vector_angle(s, c), 12868));
    end
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch word %0d %s: got %0d want %0d", n_got, what, got, want);
  endtask

  always @(posedge clk) begin
    angles_t e;
    if (!rst && done) begin
      if (angles_q.size() == 0) report("unexpected word", 0, 0);
      else begin
        e = angles_q.pop_front();
        if (roll_angle !== e.roll) report("roll", roll_angle, e.roll);
        if (pitch_angle !== e.pitch) report("pitch", pitch_angle, e.pitch);
        if (yaw_angle !== e.yaw) report("yaw", yaw_angle, e.yaw);
        if (pitch_clamped !== e.clmp) report("clamp", pitch_clamped, e.clmp);
        if (e.clmp) n_clamp++;
      end
      n_got++;
    end
  end

  task automatic send_word(stim_t s);
    angles_t p;
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    p = predict_angles(s.w, s.x, s.y, s.z);
    if (s.typed && (p.roll !== s.exp.roll || p.pitch !== s.exp.pitch ||
                    p.yaw !== s.exp.yaw || p.clmp !== s.exp.clmp))
      report("table row vs model", n_sent, 0);
    angles_q.push_back(s.typed ? s.exp : p);
    start  <= 1'b1;
    quat_w <= s.w; quat_x <= s.x; quat_y <= s.y; quat_z <= s.z;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      2: return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom_range(32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic stim_t row(int w, int x, int y, int z, bit t = 0,
                                int r = 0, int p = 0, int yw = 0, bit c = 0);
    stim_t s;
    s.w = 16'(w); s.x = 16'(x); s.y = 16'(y); s.z = 16'(z); s.typed = t;
    s.exp.roll = 16'(r); s.exp.pitch = 15'(p); s.exp.yaw = 16'(yw);
    s.exp.clmp = c;
    return s;
  endfunction

  stim_t table_rows[$];

  initial begin
    stim_t s;
    int k;
    table_rows = '{
      row(16384, 0, 0, 0, 1, 0, 0, 0, 0),
      row(0, 0, 0, 0, 1, 0, 0, 0, 0),
      row(11585, 0, 11585, 0),
      row(11585, 0, -11585, 0),
      row(16384, 0, 16384, 0),
      row(0, 16384, 0, 0), row(0, 0, 16384, 0), row(0, 0, 0, 16384),
      row(-16384, 0, 0, 0), row(-32768, -32768, -32768, -32768),
      row(32767, 32767, 32767, 32767), row(-32768, 32767, -32768, 32767),
      row(8192, 8192, 8192, 8192), row(8192, -8192, 8192, -8192),
      row(0, 11585, 0, 11585), row(11585, 11585, 0, 0),
      row(11585, 0, 0, 11585), row(1, 0, 0, 0), row(0, 0, 1, -1),
      row(16383, 1, 1, 1), row(-1, -1, -1, -1), row(-16384, 16384, 0, 0),
      row(0, 0, 16384, 16384), row(11584, 0, 11586, 0)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) send_word(table_rows[i]);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 23 : (ph == 1) ? 52 : 0;
      for (int i = 0; i < N_RAND / 3; i++) begin
        k = $urandom_range(3);
        s = row(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        // near-gimbal words: y within 2 of +-w, x within 2 of z
        if (k == 0) begin
          s.y = s.w + 16'($urandom_range(4)) - 16'sd2;
          s.x = s.z + 16'($urandom_range(4)) - 16'sd2;
          if ($urandom_range(1)) s.y = -s.y;
        end
        send_word(s);
      end
    end
    start <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("sent %0d words, checked %0d, %0d with pitch clamped", n_sent, n_got,
             n_clamp);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
